FILE: hw/rtl/p256pd_pkg.sv
// Package for the P-256 point decompression unit: types, constants, microcode table.
package p256pd_pkg;

  localparam int unsigned CoordBytes = 32;
  localparam int unsigned FeBits     = CoordBytes * 8;
  localparam int unsigned MemDepth   = 8;
  localparam int unsigned MemAw      = $clog2(MemDepth);
  localparam int unsigned PcW        = 5;
  localparam int unsigned RepW       = 7;

  localparam logic [FeBits-1:0] P256 =
    256'hFFFFFFFF_00000001_00000000_00000000_00000000_FFFFFFFF_FFFFFFFF_FFFFFFFF;
  localparam logic [FeBits-1:0] CURVE_A =
    256'hFFFFFFFF_00000001_00000000_00000000_00000000_FFFFFFFF_FFFFFFFF_FFFFFFFC;

  typedef struct packed {
    logic [63:0] x_w3;
    logic [63:0] x_w2;
    logic [63:0] x_w1;
    logic [63:0] x_w0;
  } in_t;

  typedef struct packed {
    logic [63:0] y_w3;
    logic [63:0] y_w2;
    logic [63:0] y_w1;
    logic [63:0] y_w0;
  } out_t;

  typedef enum logic [1:0] {
    CFG_B_W0 = 2'd0,
    CFG_B_W1 = 2'd1,
    CFG_B_W2 = 2'd2,
    CFG_B_W3 = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_LDX  = 3'd0,
    OP_LDB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_ADD  = 3'd3,
    OP_ADDA = 3'd4,
    OP_FIN  = 3'd5
  } op_e;

  typedef enum logic [MemAw-1:0] {
    E_X  = 3'd0,
    E_B  = 3'd1,
    E_D  = 3'd2,
    E_T1 = 3'd3,
    E_T2 = 3'd4
  } ent_e;

  typedef struct packed {
    op_e             op;
    ent_e            dst;
    ent_e            sa;
    ent_e            sb;
    logic [RepW-1:0] n;
  } step_t;

  typedef enum logic {
    RM_ADD = 1'b0,
    RM_RED = 1'b1
  } red_mode_e;

  typedef struct packed {
    logic      start;
    red_mode_e mode;
  } red_req_t;

  localparam logic [PcW-1:0] PcLast = 5'd21;

  function automatic step_t prog(logic [PcW-1:0] pc);
    step_t s;
    s = '{OP_FIN, E_T1, E_T1, E_T1, 7'd1};
    unique case (pc)
      5'd0:  s = '{OP_LDX,  E_X,  E_X,  E_X,  7'd1};
      5'd1:  s = '{OP_LDB,  E_B,  E_B,  E_B,  7'd1};
      5'd2:  s = '{OP_MUL,  E_D,  E_X,  E_X,  7'd1};
      5'd3:  s = '{OP_ADDA, E_D,  E_D,  E_D,  7'd1};
      5'd4:  s = '{OP_MUL,  E_D,  E_D,  E_X,  7'd1};
      5'd5:  s = '{OP_ADD,  E_D,  E_D,  E_B,  7'd1};
      5'd6:  s = '{OP_MUL,  E_T1, E_D,  E_D,  7'd1};
      5'd7:  s = '{OP_MUL,  E_T1, E_T1, E_D,  7'd1};
      5'd8:  s = '{OP_MUL,  E_T2, E_T1, E_T1, 7'd2};
      5'd9:  s = '{OP_MUL,  E_T2, E_T1, E_T2, 7'd1};
      5'd10: s = '{OP_MUL,  E_T1, E_T2, E_T2, 7'd4};
      5'd11: s = '{OP_MUL,  E_T1, E_T2, E_T1, 7'd1};
      5'd12: s = '{OP_MUL,  E_T2, E_T1, E_T1, 7'd8};
      5'd13: s = '{OP_MUL,  E_T2, E_T1, E_T2, 7'd1};
      5'd14: s = '{OP_MUL,  E_T1, E_T2, E_T2, 7'd16};
      5'd15: s = '{OP_MUL,  E_T1, E_T2, E_T1, 7'd1};
      5'd16: s = '{OP_MUL,  E_T1, E_T1, E_T1, 7'd32};
      5'd17: s = '{OP_MUL,  E_T1, E_T1, E_D,  7'd1};
      5'd18: s = '{OP_MUL,  E_T1, E_T1, E_T1, 7'd96};
      5'd19: s = '{OP_MUL,  E_T1, E_T1, E_D,  7'd1};
      5'd20: s = '{OP_MUL,  E_T1, E_T1, E_T1, 7'd94};
      default: s = '{OP_FIN, E_T1, E_T1, E_T1, 7'd1};
    endcase
    return s;
  endfunction

  // signed column sum of the special-form reduction for output word idx
  function automatic logic signed [39:0] red_word(logic [15:0][31:0] c, logic [2:0] idx);
    logic signed [39:0] v [16];
    logic signed [39:0] w;
    for (int n = 0; n < 16; n++) begin
      v[n] = $signed({8'd0, c[n]});
    end
    w = '0;
    unique case (idx)
      3'd0: w = v[0] + v[8] + v[9] - v[11] - v[12] - v[13] - v[14];
      3'd1: w = v[1] + v[9] + v[10] - v[12] - v[13] - v[14] - v[15];
      3'd2: w = v[2] + v[10] + v[11] - v[13] - v[14] - v[15];
      3'd3: w = v[3] + (v[11] <<< 1) + (v[12] <<< 1) + v[13] - v[15] - v[8] - v[9];
      3'd4: w = v[4] + (v[12] <<< 1) + (v[13] <<< 1) + v[14] - v[9] - v[10];
      3'd5: w = v[5] + (v[13] <<< 1) + (v[14] <<< 1) + v[15] - v[10] - v[11];
      3'd6: w = v[6] + (v[14] <<< 1) + v[14] + (v[15] <<< 1) + v[13] - v[8] - v[9];
      3'd7: w = v[7] + (v[15] <<< 1) + v[15] + v[8] - v[10] - v[11] - v[12] - v[13];
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/p256pd_opmem.sv
// Operand memory: 256-bit entries, one write port, two registered read ports.
module p256pd_opmem (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  p256pd_pkg::ent_e                  waddr_i,
  input  logic [p256pd_pkg::FeBits-1:0]     wdata_i,
  input  logic                              re_i,
  input  p256pd_pkg::ent_e                  raddr_a_i,
  input  p256pd_pkg::ent_e                  raddr_b_i,
  output logic [p256pd_pkg::FeBits-1:0]     rdata_a_o,
  output logic [p256pd_pkg::FeBits-1:0]     rdata_b_o
);

  logic [p256pd_pkg::FeBits-1:0] mem_q [p256pd_pkg::MemDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

FILE: hw/rtl/p256pd_mul.sv
// Word-serial 256x256 schoolbook multiplier on one 32x32 multiplier.
module p256pd_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [7:0][31:0]              a_i,
  input  logic [7:0][31:0]              b_i,
  output logic [15:0][31:0]             c_o,
  output logic                          done_o
);

  logic        iss_q, pv_q, done_q;
  logic [2:0]  i_q, j_q, pi_q, pj_q;
  logic [63:0] prod_q;
  logic [31:0] carry_q;
  logic [15:0][31:0] c_q;
  logic [3:0]  idx;
  logic [31:0] cin;
  logic [63:0] t;

  assign idx = {1'b0, pi_q} + {1'b0, pj_q};
  assign cin = (pj_q == 3'd0) ? 32'd0 : carry_q;
  assign t   = prod_q + {32'd0, c_q[idx]} + {32'd0, cin};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q  <= 1'b0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
    end else begin
      done_q <= 1'b0;
      pv_q   <= iss_q;
      if (start_i) begin
        iss_q <= 1'b1;
        i_q   <= '0;
        j_q   <= '0;
      end else if (iss_q) begin
        j_q <= j_q + 3'd1;
        if (j_q == 3'd7) begin
          i_q <= i_q + 3'd1;
          if (i_q == 3'd7) begin
            iss_q <= 1'b0;
          end
        end
      end
      if (pv_q && pi_q == 3'd7 && pj_q == 3'd7) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i[i_q]) * 64'(b_i[j_q]);
    pi_q   <= i_q;
    pj_q   <= j_q;
    if (start_i) begin
      c_q <= '0;
    end else if (pv_q) begin
      c_q[idx] <= t[31:0];
      carry_q  <= t[63:32];
      if (pj_q == 3'd7) begin
        c_q[{1'b0, pi_q} + 4'd8] <= t[63:32];
      end
    end
  end

  assign c_o    = c_q;
  assign done_o = done_q;

endmodule

FILE: hw/rtl/p256pd_redc.sv
// Word-serial special-form reduction, modular add and final normalization into [0, p).
module p256pd_redc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  p256pd_pkg::red_req_t          req_i,
  input  logic [15:0][31:0]             c_i,
  input  logic [p256pd_pkg::FeBits-1:0] opa_i,
  input  logic [p256pd_pkg::FeBits-1:0] opb_i,
  output logic [p256pd_pkg::FeBits-1:0] res_o,
  output logic                          done_o
);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_WORD = 3'b010,
    R_NORM = 3'b100
  } rst_e;

  rst_e state_q;
  logic done_q;
  logic [2:0] i_q;
  logic signed [7:0] k_q;
  logic [7:0][31:0] r_q;

  logic [256:0] add_in, sum_p, diff_p;
  logic signed [39:0] accn;

  assign add_in = {1'b0, opa_i} + {1'b0, opb_i};
  assign sum_p  = {1'b0, r_q} + {1'b0, p256pd_pkg::P256};
  assign diff_p = {1'b0, r_q} - {1'b0, p256pd_pkg::P256};
  assign accn   = {{32{k_q[7]}}, k_q} + p256pd_pkg::red_word(c_i, i_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        R_IDLE: begin
          if (req_i.start) begin
            if (req_i.mode == p256pd_pkg::RM_RED) begin
              i_q     <= '0;
              k_q     <= '0;
              state_q <= R_WORD;
            end else begin
              k_q     <= {7'd0, add_in[256]};
              state_q <= R_NORM;
            end
          end
        end
        R_WORD: begin
          k_q <= accn[39:32];
          i_q <= i_q + 3'd1;
          if (i_q == 3'd7) begin
            state_q <= R_NORM;
          end
        end
        R_NORM: begin
          if (k_q[7]) begin
            k_q <= k_q + $signed({7'd0, sum_p[256]});
          end else if (k_q != 8'sd0) begin
            k_q <= k_q - $signed({7'd0, diff_p[256]});
          end else if (diff_p[256]) begin
            done_q  <= 1'b1;
            state_q <= R_IDLE;
          end
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      R_IDLE: begin
        if (req_i.start && req_i.mode == p256pd_pkg::RM_ADD) begin
          r_q <= add_in[255:0];
        end
      end
      R_WORD: r_q[i_q] <= accn[31:0];
      R_NORM: begin
        if (k_q[7]) begin
          r_q <= sum_p[255:0];
        end else if (k_q != 8'sd0 || !diff_p[256]) begin
          r_q <= diff_p[255:0];
        end
      end
      default: r_q <= r_q;
    endcase
  end

  assign res_o  = r_q;
  assign done_o = done_q;

endmodule

FILE: hw/rtl/p256_point_decompress_unit.sv
// P-256 point decompression top level: sequencer, curve-b registers, operand memory, output beat.
// One x coordinate is taken at a time and yields one even y. An item runs a fixed
// microcode of 262 modular products plus a few adds, all through one shared 32x32
// multiplier: each product runs 64 word products on the multiplier, 8 reduction
// words, then normalization and the operand memory read and write. A finished y
// waits in the output register while the next x is accepted. curve_b words may be
// written at any time the unit is idle; no clearing pass is needed after reset.
module p256_point_decompress_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  p256pd_pkg::in_t      in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output p256pd_pkg::out_t     out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_EXEC  = 6'b000100,
    S_MUL   = 6'b001000,
    S_RED   = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [p256pd_pkg::PcW-1:0]  pc_q, pc_d;
  logic [p256pd_pkg::RepW-1:0] rep_q, rep_d;
  p256pd_pkg::in_t   x_q;
  p256pd_pkg::out_t  out_q;
  logic              out_valid_q, out_valid_d, out_load;
  logic [3:0][63:0]  b_q;
  p256pd_pkg::step_t step;

  logic mem_re, mem_we;
  p256pd_pkg::ent_e raddr_a, raddr_b;
  logic [p256pd_pkg::FeBits-1:0] rd_a, rd_b, opa, opb, red_res, y_neg, y_fin;
  logic [15:0][31:0] prod;
  logic mul_start, mul_done, red_done;
  p256pd_pkg::red_req_t red_req;

  assign step        = p256pd_pkg::prog(pc_q);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (p256pd_pkg::cfg_idx_e'(cfg_index_i))
        p256pd_pkg::CFG_B_W0: b_q[0] <= cfg_data_i;
        p256pd_pkg::CFG_B_W1: b_q[1] <= cfg_data_i;
        p256pd_pkg::CFG_B_W2: b_q[2] <= cfg_data_i;
        p256pd_pkg::CFG_B_W3: b_q[3] <= cfg_data_i;
        default: b_q <= b_q;
      endcase
    end
  end

  assign raddr_a = (rep_q != '0) ? step.dst : step.sa;
  assign raddr_b = (rep_q != '0) ? step.dst : step.sb;

  always_comb begin
    unique case (step.op)
      p256pd_pkg::OP_LDX:  begin opa = x_q;  opb = '0;                  end
      p256pd_pkg::OP_LDB:  begin opa = b_q;  opb = '0;                  end
      p256pd_pkg::OP_ADDA: begin opa = rd_a; opb = p256pd_pkg::CURVE_A; end
      default:             begin opa = rd_a; opb = rd_b;                end
    endcase
  end

  assign y_neg    = p256pd_pkg::P256 - rd_a;
  assign y_fin    = rd_a[0] ? y_neg : rd_a;
  assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d       = state_q;
    pc_d          = pc_q;
    rep_d         = rep_q;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mul_start     = 1'b0;
    red_req.start = 1'b0;
    red_req.mode  = p256pd_pkg::RM_ADD;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pc_d    = '0;
          rep_d   = '0;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        mem_re  = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (step.op)
          p256pd_pkg::OP_MUL: begin
            mul_start = 1'b1;
            state_d   = S_MUL;
          end
          p256pd_pkg::OP_FIN: state_d = S_FIN;
          default: begin
            red_req.start = 1'b1;
            state_d       = S_RED;
          end
        endcase
      end
      S_MUL: begin
        if (mul_done) begin
          red_req.start = 1'b1;
          red_req.mode  = p256pd_pkg::RM_RED;
          state_d       = S_RED;
        end
      end
      S_RED: begin
        if (red_done) begin
          mem_we = 1'b1;
          if (step.op == p256pd_pkg::OP_MUL && rep_q != 7'(step.n - 7'd1)) begin
            rep_d = rep_q + 7'd1;
          end else begin
            rep_d = '0;
            pc_d  = pc_q + 5'd1;
          end
          state_d = S_FETCH;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      rep_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      x_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= y_fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  p256pd_opmem u_opmem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (step.dst),
    .wdata_i   (red_res),
    .re_i      (mem_re),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  p256pd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (rd_a),
    .b_i     (rd_b),
    .c_o     (prod),
    .done_o  (mul_done)
  );

  p256pd_redc u_redc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (red_req),
    .c_i    (prod),
    .opa_i  (opa),
    .opb_i  (opb),
    .res_o  (red_res),
    .done_o (red_done)
  );

  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_MUL)
    else $error("multiplier finished outside product wait");

  a_red_done_in_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_done |-> state_q == S_RED)
    else $error("reduction finished outside reduce wait");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("output beat loaded outside final step");

  a_out_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !out_q.y_w0[0])
    else $error("odd y delivered");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> pc_q <= p256pd_pkg::PcLast)
    else $error("microcode pointer past end");

endmodule

FILE: test/tb_p256_point_decompress_unit.sv
// Testbench for the P-256 point decompression unit: random and directed x, predicted even y.
module tb_p256_point_decompress_unit;

  localparam logic [255:0] CurveB =
    256'h5AC635D8_AA3A93E7_B3EBBD55_769886BC_651D06B0_CC53B0F6_3BCE3C3E_27D2604B;
  localparam logic [255:0] GenX =
    256'h6B17D1F2_E12C4247_F8BCE6E5_63A440F2_77037D81_2DEB33A0_F4A13945_D898C296;
  localparam int unsigned CycleLimit = 20_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  p256pd_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  p256pd_pkg::out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  p256_point_decompress_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [255:0] x_pending[$];
  p256pd_pkg::out_t y_expected[$];
  logic [63:0] b_word[4];
  int errors = 0;
  bit quiet = 1'b0;
  int unsigned cycles = 0;

  function automatic logic [255:0] fmul(logic [255:0] a, logic [255:0] b);
    logic [511:0] w;
    w = {256'd0, a} * {256'd0, b};
    w = w % {256'd0, p256pd_pkg::P256};
    return w[255:0];
  endfunction

  function automatic logic [255:0] fsqr_n(logic [255:0] a, int n);
    logic [255:0] r;
    r = a;
    for (int i = 0; i < n; i++) r = fmul(r, r);
    return r;
  endfunction

  function automatic logic [255:0] fadd(logic [255:0] a, logic [255:0] b);
    logic [256:0] s;
    s = {1'b0, a} + {1'b0, b};
    s = s % {1'b0, p256pd_pkg::P256};
    return s[255:0];
  endfunction

  function automatic p256pd_pkg::out_t even_y_of(logic [255:0] x_raw);
    logic [255:0] x, b, d, t1, t2, y;
    p256pd_pkg::out_t r;
    x = x_raw % p256pd_pkg::P256;
    b = {b_word[3], b_word[2], b_word[1], b_word[0]} % p256pd_pkg::P256;
    d = fmul(fadd(fmul(x, x), p256pd_pkg::CURVE_A), x);
    d = fadd(d, b);
    t1 = fmul(fmul(d, d), d);
    t2 = fmul(t1, fsqr_n(t1, 2));
    t1 = fmul(t2, fsqr_n(t2, 4));
    t2 = fmul(t1, fsqr_n(t1, 8));
    t1 = fmul(t2, fsqr_n(t2, 16));
    t1 = fmul(fsqr_n(t1, 32), d);
    t1 = fmul(fsqr_n(t1, 96), d);
    y = fsqr_n(t1, 94);
    if (y[0]) y = p256pd_pkg::P256 - y;
    r = y;
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        y_expected.push_back(even_y_of(in_data_i));
        busy = 1'b0;
      end
      if (busy) begin
        in_valid_i <= 1'b1;
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (x_pending.size() > 0) begin
        in_data_i <= x_pending.pop_front();
        in_valid_i <= 1'b1;
        in_gap <= quiet ? 0 : $urandom_range(0, 11);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    p256pd_pkg::out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (y_expected.size() == 0) begin
          report("unexpected beat y_w0", out_data_o.y_w0, 64'd0);
        end else begin
          want = y_expected.pop_front();
          if (out_data_o.y_w0 !== want.y_w0) report("y_w0", out_data_o.y_w0, want.y_w0);
          if (out_data_o.y_w1 !== want.y_w1) report("y_w1", out_data_o.y_w1, want.y_w1);
          if (out_data_o.y_w2 !== want.y_w2) report("y_w2", out_data_o.y_w2, want.y_w2);
          if (out_data_o.y_w3 !== want.y_w3) report("y_w3", out_data_o.y_w3, want.y_w3);
        end
        out_gap <= quiet ? 0 : $urandom_range(0, 11);
        out_stall_i <= !quiet;
      end else begin
        out_stall_i <= (out_gap > 1);
        if (out_gap > 0) out_gap <= out_gap - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_b(logic [255:0] b);
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= p256pd_pkg::cfg_idx_e'(i);
      cfg_data_i <= b[64*i +: 64];
      do @(posedge clk_i); while (!cfg_ready_o);
      b_word[i] = b[64*i +: 64];
      cfg_valid_i <= 1'b0;
    end
  endtask

  function automatic logic [255:0] rand_x();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
    case ($urandom_range(0, 9))
      0: v = p256pd_pkg::P256 - v[15:0];
      1: v = p256pd_pkg::P256 + v[15:0];
      2: v = {224'd0, v[31:0]};
      default: ;
    endcase
    return v;
  endfunction

  task automatic drain();
    wait (x_pending.size() == 0 && !in_valid_i && y_expected.size() == 0);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    logic [255:0] b_set[5];
    int n_rand[5];
    for (int i = 0; i < 4; i++) b_word[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    b_set[0] = CurveB;
    b_set[1] = '0;
    b_set[2] = '1;
    b_set[3] = p256pd_pkg::P256 - 1;
    for (int i = 0; i < 8; i++) b_set[4][32*i +: 32] = $urandom;
    n_rand = '{60, 30, 30, 30, 40};

    for (int ph = 0; ph < 5; ph++) begin
      write_b(b_set[ph]);
      quiet = (ph == 2);
      if (ph < 2) begin
        x_pending.push_back('0);
        x_pending.push_back(256'd1);
        x_pending.push_back(p256pd_pkg::P256 - 1);
        x_pending.push_back(p256pd_pkg::P256);
        x_pending.push_back('1);
        x_pending.push_back(GenX);
        x_pending.push_back({64{4'h5}});
        x_pending.push_back({64{4'hA}});
      end
      for (int i = 0; i < n_rand[ph]; i++) x_pending.push_back(rand_x());
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
